[src/lms_pkg.sv]
// lms_pkg: shared constants for the lms autoassociative trainer
// used by lms_autoassociative_trainer and its checker
`default_nettype none
package lms_pkg;
   localparam int DimDefault      = 4;
   localparam int PatternsDefault = 2;
   localparam int ElemWidth       = 16;
   localparam int ErrWidth        = 18;
   localparam int RateWidth       = 16;
   localparam int EpochWidth      = 8;
   localparam int CsrIdxWidth     = 1;
   localparam logic [CsrIdxWidth-1:0] CsrLearningRate = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CsrEpochCount   = 1'd1;
   localparam logic [RateWidth-1:0]  RateReset  = 16'd9830;
   localparam logic [EpochWidth-1:0] EpochReset = 8'd30;
endpackage
`default_nettype wire

[src/lms_autoassociative_trainer.sv]
// lms_autoassociative_trainer: batch widrow-hoff trainer top level
// depends on lms_pkg
//
// usage: pattern elements enter on req_ (valid/stall), component-major,
// DIM*PATTERNS of them. after the last one the block clears the weights
// and trains epoch_count epochs, then sends DIM*DIM weights on rsp_ in
// row-major order, last_weight marking the final one.
// req_stall is high from the last element until the final weight is
// taken; elements before the last are taken one per cycle.
// training runs on a multiplier shared by the output and update sums,
// plus a rate multiplier, with registered-read memories.
// a stalled rsp_ transaction holds its payload; the block waits.
// reset (synchronous, active high) clears control and restores the
// register defaults; weights are cleared at the start of each training.
// csr_ writes land at once, to be done while the block is idle.
`default_nettype none
module lms_autoassociative_trainer #(
   parameter int DIM      = lms_pkg::DimDefault,
   parameter int PATTERNS = lms_pkg::PatternsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [lms_pkg::ElemWidth-1:0] req_pattern_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [lms_pkg::ElemWidth-1:0] rsp_weight_value,
   output      logic [1:0]                          rsp_weight_row,
   output      logic [1:0]                          rsp_weight_col,
   output      logic                                rsp_last_weight,
   input  wire logic                                csr_write,
   input  wire logic [lms_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [lms_pkg::RateWidth-1:0]       csr_data
);
   localparam int NElem = DIM * PATTERNS;
   localparam int NW    = DIM * DIM;
   localparam int EW    = (NElem > 1) ? $clog2(NElem) : 1;
   localparam int WW    = $clog2(NW);
   localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int PW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int DCW   = $clog2(DIM + 1);
   localparam int PCW   = $clog2(PATTERNS + 1);
   localparam int AccW  = 48;
   localparam int UpdW  = 40;
   localparam int DpW   = UpdW + lms_pkg::RateWidth + 1;

   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_ORD   = 9'b000000100,
      S_OMAC  = 9'b000001000,
      S_OFIN  = 9'b000010000,
      S_URD   = 9'b000100000,
      S_UMAC  = 9'b001000000,
      S_UFIN  = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] pat_mem [NElem];
   logic signed [15:0] w_mem   [NW];
   logic signed [17:0] err_mem [NElem];

   logic [15:0] rate_ff;
   logic [7:0]  epochs_ff;
   logic [EW-1:0] load_ff, load_in;
   logic [7:0]  ep_ff, ep_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in;
   logic [PW-1:0] k_ff, k_in;
   logic [DCW-1:0] t_ff, t_in;        // inner term counter for output pass
   logic [PCW-1:0] u_ff, u_in;        // inner term counter for update pass
   logic [1:0] ph_ff, ph_in;          // read / multiply / accumulate phase
   logic [WW:0] n_ff, n_in;
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic signed [35:0] prod_ff;
   logic signed [17:0] opa_ff, opa_in;
   logic signed [15:0] opb_ff, opb_in;
   logic signed [15:0] rb_ff;
   logic signed [17:0] re_ff;
   logic signed [15:0] rw_ff;
   logic [EW-1:0] ra_addr, rb_addr;
   logic [WW-1:0] rw_addr;
   logic rv_ff, rv_in;
   logic signed [15:0] rsp_val_ff;
   logic [1:0] row_ff, col_ff;
   logic last_ff;
   logic we_w;
   logic [WW-1:0] w_waddr;
   logic signed [15:0] w_wdata;
   logic we_e;
   logic [EW-1:0] e_waddr;
   logic signed [17:0] e_wdata;
   logic signed [AccW-1:0] rnd_o, rnd_d, sum_w;
   logic signed [DpW-1:0] dprod_ff;
   logic signed [AccW-1:0] e_diff;

   wire req_acc = req_valid && !req_stall;
   wire rsp_free = !rv_ff || !rsp_stall;

   assign req_stall = (state_ff != S_LOAD) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_weight_value = rsp_val_ff;
   assign rsp_weight_row = row_ff;
   assign rsp_weight_col = col_ff;
   assign rsp_last_weight = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= lms_pkg::RateReset;
         epochs_ff <= lms_pkg::EpochReset;
      end else if (csr_write) begin
         if (csr_index == lms_pkg::CsrLearningRate) rate_ff <= csr_data;
         if (csr_index == lms_pkg::CsrEpochCount) epochs_ff <= csr_data[7:0];
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (req_acc) pat_mem[load_ff] <= req_pattern_value;
      rb_ff <= pat_mem[rb_addr];
      re_ff <= err_mem[ra_addr];
      rw_ff <= w_mem[rw_addr];
      if (we_w) w_mem[w_waddr] <= w_wdata;
      if (we_e) err_mem[e_waddr] <= e_wdata;
   end

   // address generation
   always_comb begin
      ra_addr = '0;
      rb_addr = '0;
      rw_addr = '0;
      unique case (state_ff)
         S_OMAC: begin
            rw_addr = WW'(i_ff * DIM + j_ff);
            rb_addr = EW'(j_ff * PATTERNS + k_ff);
         end
         S_OFIN: rb_addr = EW'(i_ff * PATTERNS + k_ff);
         S_UMAC: begin
            ra_addr = EW'(i_ff * PATTERNS + k_ff);
            rb_addr = EW'(j_ff * PATTERNS + k_ff);
         end
         S_UFIN, S_EMIT: rw_addr = WW'(n_ff[WW-1:0]);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa_ff * opb_ff;
      dprod_ff <= $signed(acc_ff[UpdW-1:0]) * $signed({1'b0, rate_ff});
   end

   assign rnd_o = acc_ff + (AccW'(1) <<< 11);
   assign e_diff = AccW'(rb_ff) - (rnd_o >>> 12);
   assign rnd_d = AccW'((dprod_ff + (DpW'(1) <<< 27)) >>> 28);
   assign sum_w = AccW'(rw_ff) + rnd_d;

   always_comb begin
      state_in = state_ff;
      load_in = load_ff;
      ep_in = ep_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      t_in = t_ff; u_in = u_ff; ph_in = ph_ff; n_in = n_ff;
      acc_in = acc_ff; opa_in = opa_ff; opb_in = opb_ff;
      rv_in = rv_ff && rsp_stall;
      we_w = 1'b0; w_waddr = '0; w_wdata = '0;
      we_e = 1'b0; e_waddr = '0; e_wdata = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (load_ff == EW'(NElem - 1)) begin
                  load_in = '0;
                  n_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  load_in = load_ff + 1'b1;
               end
            end
         end
         S_CLEAR: begin
            we_w = 1'b1;
            w_waddr = n_ff[WW-1:0];
            n_in = n_ff + 1'b1;
            if (n_ff == (WW+1)'(NW - 1)) begin
               ep_in = '0;
               n_in = '0;
               state_in = S_ORD;
            end
         end
         S_ORD: begin
            i_in = '0; j_in = '0; k_in = '0; t_in = '0; ph_in = '0;
            n_in = '0;
            acc_in = '0;
            if (ep_ff == epochs_ff) state_in = S_EMIT;
            else state_in = S_OMAC;
         end
         S_OMAC: begin
            // ph 0: read, 1: load operands, 2: multiply, 3: accumulate
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd1) begin
               opa_in = 18'(rw_ff);
               opb_in = rb_ff;
            end
            if (ph_ff == 2'd3) begin
               acc_in = acc_ff + AccW'(prod_ff);
               ph_in = '0;
               if (t_ff == DCW'(DIM - 1)) begin
                  t_in = '0;
                  state_in = S_OFIN;
               end else begin
                  t_in = t_ff + 1'b1;
                  j_in = j_ff + 1'b1;
               end
            end
         end
         S_OFIN: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd1) begin
               we_e = 1'b1;
               e_waddr = EW'(i_ff * PATTERNS + k_ff);
               if (e_diff > 48'sd131071) e_wdata = 18'sd131071;
               else if (e_diff < -48'sd131072) e_wdata = -18'sd131072;
               else e_wdata = e_diff[17:0];
               ph_in = '0;
               acc_in = '0;
               j_in = '0;
               state_in = S_OMAC;
               if (k_ff == PW'(PATTERNS - 1)) begin
                  k_in = '0;
                  if (i_ff == DW'(DIM - 1)) begin
                     i_in = '0;
                     state_in = S_URD;
                  end else i_in = i_ff + 1'b1;
               end else k_in = k_ff + 1'b1;
            end
         end
         S_URD: begin
            acc_in = '0; ph_in = '0; u_in = '0; k_in = '0;
            state_in = S_UMAC;
         end
         S_UMAC: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd1) begin
               opa_in = re_ff;
               opb_in = rb_ff;
            end
            if (ph_ff == 2'd3) begin
               acc_in = acc_ff + AccW'(prod_ff);
               ph_in = '0;
               if (u_ff == PCW'(PATTERNS - 1)) begin
                  u_in = '0;
                  k_in = '0;
                  n_in = (WW+1)'(i_ff * DIM + j_ff);
                  state_in = S_UFIN;
               end else begin
                  u_in = u_ff + 1'b1;
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_UFIN: begin
            // ph 0: weight read + rate multiply, 1: wait, 2: write
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               we_w = 1'b1;
               w_waddr = n_ff[WW-1:0];
               if (sum_w > 48'sd32767) w_wdata = 16'sh7fff;
               else if (sum_w < -48'sd32768) w_wdata = -16'sh8000;
               else w_wdata = sum_w[15:0];
               ph_in = '0;
               acc_in = '0;
               state_in = S_UMAC;
               if (j_ff == DW'(DIM - 1)) begin
                  j_in = '0;
                  if (i_ff == DW'(DIM - 1)) begin
                     i_in = '0;
                     ep_in = ep_ff + 1'b1;
                     state_in = S_ORD;
                  end else i_in = i_ff + 1'b1;
               end else j_in = j_ff + 1'b1;
            end
         end
         S_EMIT: begin
            // ph 0: read, 1: present
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (rsp_free) begin
               rv_in = 1'b1;
               ph_in = '0;
               if (j_ff == DW'(DIM - 1)) begin
                  j_in = '0;
                  if (i_ff == DW'(DIM - 1)) i_in = '0;
                  else i_in = i_ff + 1'b1;
               end else j_in = j_ff + 1'b1;
               if (n_ff == (WW+1)'(NW - 1)) begin
                  n_in = '0;
                  state_in = S_LOAD;
               end else n_in = n_ff + 1'b1;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      if (state_ff == S_EMIT && ph_ff == 2'd1 && rsp_free) begin
         rsp_val_ff <= rw_ff;
         row_ff <= 2'(i_ff);
         col_ff <= 2'(j_ff);
         last_ff <= (n_ff == (WW+1)'(NW - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         load_ff <= '0;
         ep_ff <= '0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0;
         t_ff <= '0; u_ff <= '0; ph_ff <= '0; n_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff <= load_in;
         ep_ff <= ep_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
         t_ff <= t_in; u_ff <= u_in; ph_ff <= ph_in; n_ff <= n_in;
         rv_ff <= rv_in;
      end
   end
endmodule
`default_nettype wire

[src/lms_checker.sv]
// lms_checker: port-level assertions for lms_autoassociative_trainer
// depends on lms_pkg; bound to the top level below
`default_nettype none
module lms_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_last_weight,
   input wire logic [1:0] rsp_weight_row,
   input wire logic [1:0] rsp_weight_col,
   input wire logic [lms_pkg::ElemWidth-1:0] rsp_weight_value
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_value))
      else $error("stalled transaction changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while emitting");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_weight |-> rsp_weight_row == rsp_weight_col)
      else $error("last weight off diagonal");
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(req_stall) |-> rsp_weight_row == 2'd0)
      else $error("emission does not start at row zero");
endmodule

bind lms_autoassociative_trainer lms_checker u_lms_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last_weight(rsp_last_weight),
   .rsp_weight_row(rsp_weight_row), .rsp_weight_col(rsp_weight_col),
   .rsp_weight_value(rsp_weight_value)
);
`default_nettype wire

[sim/tb_lms_autoassociative_trainer.sv]
// tb_lms_autoassociative_trainer: self-checking testbench for the lms trainer
// loads pattern sets, predicts the trained weight matrix, checks every rsp_ transaction
// depends on lms_pkg and lms_autoassociative_trainer
`timescale 1ns / 100ps
`default_nettype none
module tb_lms_autoassociative_trainer;
   import lms_pkg::*;

   localparam int NumElem   = DimDefault * PatternsDefault;
   localparam int NumWeight = DimDefault * DimDefault;
   localparam int CycleLimit = 3000000;

   typedef struct packed {
      logic signed [ElemWidth-1:0] value;
      logic [1:0]                  row;
      logic [1:0]                  col;
      logic                        last;
   } weight_type;

   typedef struct {
      logic signed [ElemWidth-1:0] value;
      bit                          zero_set;
   } load_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [ElemWidth-1:0] req_pattern_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [ElemWidth-1:0] rsp_weight_value;
   logic [1:0]                  rsp_weight_row;
   logic [1:0]                  rsp_weight_col;
   logic                        rsp_last_weight;
   logic                        csr_write;
   logic [CsrIdxWidth-1:0]      csr_index;
   logic [RateWidth-1:0]        csr_data;

   lms_autoassociative_trainer dut (
      .clock, .reset, .req_valid, .req_stall, .req_pattern_value,
      .rsp_valid, .rsp_stall, .rsp_weight_value, .rsp_weight_row,
      .rsp_weight_col, .rsp_last_weight, .csr_write, .csr_index, .csr_data
   );

   always #4 clock = ~clock;

   weight_type   expected_weights[$];
   longint       loaded_pattern[NumElem];
   int           load_count;
   int           items_sent;
   int           error_count;
   longint       cycle_count;
   logic [RateWidth-1:0]  eta;
   logic [EpochWidth-1:0] epochs;
   bit           long_hold;
   load_row_type load_table[24];

   task automatic report(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // batch widrow-hoff training from cleared weights (all zeros for a zero set), then queue the matrix
   function automatic void train_and_queue(input bit typed_zero);
      longint     w[NumWeight];
      longint     err[NumElem];
      longint     acc;
      weight_type wt;
      for (int n = 0; n < NumWeight; n++) w[n] = 0;
      if (!typed_zero) begin
         for (int ep = 0; ep < epochs; ep++) begin
            for (int i = 0; i < DimDefault; i++) begin
               for (int k = 0; k < PatternsDefault; k++) begin
                  acc = 0;
                  for (int j = 0; j < DimDefault; j++)
                     acc += w[i*DimDefault+j] * loaded_pattern[j*PatternsDefault+k];
                  acc = (acc + (64'sd1 <<< 11)) >>> 12;
                  err[i*PatternsDefault+k] =
                     clip(loaded_pattern[i*PatternsDefault+k] - acc, -131072, 131071);
               end
            end
            for (int i = 0; i < DimDefault; i++) begin
               for (int j = 0; j < DimDefault; j++) begin
                  acc = 0;
                  for (int k = 0; k < PatternsDefault; k++)
                     acc += err[i*PatternsDefault+k] * loaded_pattern[j*PatternsDefault+k];
                  acc = (acc * longint'(eta) + (64'sd1 <<< 27)) >>> 28;
                  w[i*DimDefault+j] = clip(w[i*DimDefault+j] + acc, -32768, 32767);
               end
            end
         end
      end
      for (int n = 0; n < NumWeight; n++) begin
         wt.value = typed_zero ? '0 : ElemWidth'(w[n]);
         wt.row   = 2'(n / DimDefault);
         wt.col   = 2'(n % DimDefault);
         wt.last  = (n == NumWeight - 1);
         expected_weights.push_back(wt);
      end
   endfunction

   // called at a rising edge; returns at the edge the element is taken
   task automatic send_element(input logic signed [ElemWidth-1:0] v, input bit typed_zero);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pattern_value <= v;
      do @(posedge clock); while (req_stall);
      items_sent++;
      loaded_pattern[load_count] = longint'(v);
      load_count++;
      if (load_count == NumElem) begin
         load_count = 0;
         train_and_queue(typed_zero);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= RateWidth'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CsrLearningRate) eta = RateWidth'(value);
      else epochs = EpochWidth'(value);
   endtask

   task automatic configure(input int unsigned rate, input int unsigned count);
      wait_idle();
      write_csr(CsrLearningRate, rate);
      write_csr(CsrEpochCount, count);
   endtask

   function automatic logic signed [ElemWidth-1:0] random_element(input int style);
      case (style)
         0: return ElemWidth'($urandom);
         1: return ElemWidth'($urandom_range(0, 8192) - 4096);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'sh1000;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_sets(input int sets);
      int style;
      for (int s = 0; s < sets; s++) begin
         if ($urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            while (expected_weights.size() != 0) @(posedge clock);
         end
         style = ($urandom_range(0, 4) < 3) ? 1 : $urandom_range(0, 2);
         for (int e = 0; e < NumElem; e++) send_element(random_element(style), 1'b0);
      end
   endtask

   // receiver back-pressure
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (long_hold) begin
            hold = 600;
            long_hold = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   // weight checker
   always @(posedge clock) begin
      weight_type exp_w;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_weights.size() == 0) begin
            report("weight transaction with nothing expected");
         end else begin
            exp_w = expected_weights.pop_front();
            if (rsp_weight_value !== exp_w.value)
               report($sformatf("weight_value got %0d want %0d (row %0d col %0d)",
                  rsp_weight_value, exp_w.value, exp_w.row, exp_w.col));
            if (rsp_weight_row !== exp_w.row)
               report($sformatf("weight_row got %0d want %0d", rsp_weight_row, exp_w.row));
            if (rsp_weight_col !== exp_w.col)
               report($sformatf("weight_col got %0d want %0d", rsp_weight_col, exp_w.col));
            if (rsp_last_weight !== exp_w.last)
               report($sformatf("last_weight got %0d want %0d", rsp_last_weight, exp_w.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      cycle_count       = 0;
      error_count       = 0;
      items_sent        = 0;
      load_count        = 0;
      long_hold         = 1'b0;
      eta               = RateReset;
      epochs            = EpochReset;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_pattern_value = '0;
      csr_write         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;

      // all-zero set, then extremes and alternating-bit values, then multiples of 16'sh0800
      for (int r = 0; r < 8; r++) load_table[r] = '{16'sh0000, 1'b1};
      load_table[8]  = '{16'sh7fff, 1'b0};
      load_table[9]  = '{16'sh8000, 1'b0};
      load_table[10] = '{16'sh8000, 1'b0};
      load_table[11] = '{16'sh7fff, 1'b0};
      load_table[12] = '{16'shffff, 1'b0};
      load_table[13] = '{16'sh0001, 1'b0};
      load_table[14] = '{16'sh5555, 1'b0};
      load_table[15] = '{16'shaaaa, 1'b0};
      load_table[16] = '{16'sh1000, 1'b0};
      load_table[17] = '{16'sh0000, 1'b0};
      load_table[18] = '{16'sh0000, 1'b0};
      load_table[19] = '{16'sh1000, 1'b0};
      load_table[20] = '{16'shf000, 1'b0};
      load_table[21] = '{16'sh0800, 1'b0};
      load_table[22] = '{16'sh0000, 1'b0};
      load_table[23] = '{16'shf800, 1'b0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < 24; r++) send_element(load_table[r].value, load_table[r].zero_set);

      configure(0, 1);
      send_random_sets(2);
      configure(65535, 255);
      send_random_sets(1);
      configure(65535, 1);
      send_random_sets(2);
      configure($urandom_range(0, 65535), 0);
      send_random_sets(1);
      configure(1, 30);
      long_hold = 1'b1;
      send_random_sets(3);
      configure(9830, 30);
      send_random_sets(2);

      while (items_sent < 500) begin
         case ($urandom_range(0, 3))
            0: configure(65535, $urandom_range(1, 6));
            1: configure($urandom_range(0, 255), $urandom_range(1, 6));
            default: configure($urandom_range(0, 65535), $urandom_range(1, 6));
         endcase
         send_random_sets(4);
      end

      req_valid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
